FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the depth normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DMN_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("dmn assertion failed");

// Next-cycle implication.
`define DMN_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("dmn assertion failed");

`endif

FILE: hw/rtl/dmn_pkg.sv
// Types and constants of the depth min-max normalizer.
package dmn_pkg;

	localparam int SIDE_W = 13;
	localparam int CNT_W  = 2 * SIDE_W;
	localparam int GREY_W = 8;

	localparam logic [SIDE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIDE_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [GREY_W-1:0] GREY_MAX     = 8'hFF;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic valid;
		logic last;
		logic zero;
		logic sat;
	} dmn_ctl_t;

endpackage

FILE: hw/rtl/dmn_div_cell.sv
// One restoring-division cell: resolves one quotient bit per pipeline step.
`include "assert_macros.svh"

module dmn_div_cell #(
	parameter int DW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  dmn_pkg::dmn_ctl_t           ctl_in,
	input  logic [DW-1:0]               rem_in,
	input  logic [dmn_pkg::GREY_W-1:0]  low_in,
	input  logic [DW-1:0]               den_in,
	input  logic [dmn_pkg::GREY_W-1:0]  quo_in,
	output dmn_pkg::dmn_ctl_t           ctl_q,
	output logic [DW-1:0]               rem_q,
	output logic [dmn_pkg::GREY_W-1:0]  low_q,
	output logic [DW-1:0]               den_q,
	output logic [dmn_pkg::GREY_W-1:0]  quo_q
);

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_in, low_in[dmn_pkg::GREY_W-1]};
	assign diff  = trial - {1'b0, den_in};
	assign ge    = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			low_q <= {low_in[dmn_pkg::GREY_W-2:0], 1'b0};
			den_q <= den_in;
			quo_q <= {quo_in[dmn_pkg::GREY_W-2:0], ge};
		end
	end

	// partial remainder stays below the divisor
	`DMN_ASSERT_IMPLIES(a_rem_bound, clk, arst_n, ctl_q.valid && !ctl_q.zero && !ctl_q.sat, rem_q < den_q)

endmodule

FILE: hw/rtl/dmn_tracker.sv
// Pass tracking, running min/max and per-sample front end of the normalizer.
`include "assert_macros.svh"

module dmn_tracker #(
	parameter int DW = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       sample_valid,
	input  logic [DW-1:0]              sample,
	input  logic [dmn_pkg::CNT_W-1:0]  size,
	output dmn_pkg::dmn_ctl_t          ctl_s1,
	output logic [DW-1:0]              x_s1,
	output logic [DW-1:0]              den_s1
);

	logic [DW-1:0]             min_q;
	logic [DW-1:0]             max_q;
	logic [dmn_pkg::CNT_W-1:0] count_q;
	logic                      phase_q;
	logic                      acc;
	logic                      conv;
	logic [dmn_pkg::CNT_W:0]   count_next;
	logic                      last;
	dmn_pkg::dmn_ctl_t         ctl_d;

	assign acc        = sample_valid && en;
	assign conv       = acc && phase_q;
	assign count_next = {1'b0, count_q} + 1'b1;
	assign last       = count_next >= {1'b0, size};

	always_comb begin
		ctl_d = '0;
		if (conv) begin
			ctl_d.valid = 1'b1;
			ctl_d.last  = last;
			ctl_d.zero  = (max_q <= min_q) || (sample <= min_q);
			ctl_d.sat   = (max_q > min_q) && (sample > min_q) && (sample >= max_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '1;
			max_q   <= '0;
			count_q <= '0;
			phase_q <= 1'b0;
			ctl_s1  <= '0;
		end else begin
			if (en) begin
				ctl_s1 <= ctl_d;
			end
			if (acc) begin
				if (!phase_q) begin
					if (sample < min_q) begin
						min_q <= sample;
					end
					if (sample > max_q) begin
						max_q <= sample;
					end
					if (last) begin
						count_q <= '0;
						phase_q <= 1'b1;
					end else begin
						count_q <= count_next[dmn_pkg::CNT_W-1:0];
					end
				end else begin
					if (last) begin
						min_q   <= '1;
						max_q   <= '0;
						count_q <= '0;
						phase_q <= 1'b0;
					end else begin
						count_q <= count_next[dmn_pkg::CNT_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1   <= sample - min_q;
			den_s1 <= max_q - min_q;
		end
	end

	// a measured frame always has min <= max
	`DMN_ASSERT_IMPLIES(a_minmax_order, clk, arst_n, phase_q, min_q <= max_q)
	// final convert sample restarts the measuring pass
	`DMN_ASSERT_NEXT(a_frame_restart, clk, arst_n, acc && phase_q && last, !phase_q && (max_q == '0) && (count_q == '0))

endmodule

FILE: hw/rtl/depth_minmax_normalize_unit.sv
// Top level: depth frame min-max normalizer to 8-bit grey.
// A convert-pass result goes through the front, prep, division-cell and output registers.
// Throughput: one sample per cycle; the front stage, a 255x prep stage and a
// chain of 8 one-bit division cells all advance together, halting while a result is stalled.
// Measuring-pass samples give no result; the frame size costs one 13x13 multiply per cycle.
// Reset: asynchronous; clears size registers to 640x480, min/max, pass state and valid bits.
`include "assert_macros.svh"

module depth_minmax_normalize_unit #(
	parameter int DEPTH_BITS = 24,
	parameter int MAX_SIDE   = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [dmn_pkg::SIDE_W-1:0]   cfg_data,
	input  logic                         depth_valid,
	output logic                         depth_stall,
	input  logic [DEPTH_BITS-1:0]        depth_sample,
	output logic                         grey_valid,
	input  logic                         grey_stall,
	output logic [dmn_pkg::GREY_W-1:0]   grey_level,
	output logic                         frame_end
);

	localparam int DW     = DEPTH_BITS;
	localparam int GW     = dmn_pkg::GREY_W;
	localparam int SW     = dmn_pkg::SIDE_W;
	localparam int CW     = dmn_pkg::CNT_W;

	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;
	logic [SW-1:0] width_eff;
	logic [SW-1:0] height_eff;
	logic [CW-1:0] size;
	logic          adv;

	dmn_pkg::dmn_ctl_t ctl_s1;
	logic [DW-1:0]     x_s1;
	logic [DW-1:0]     den_s1;
	logic [DW+GW-1:0]  num;

	dmn_pkg::dmn_ctl_t ctl_s2;
	logic [DW-1:0]     rem_s2;
	logic [GW-1:0]     low_s2;
	logic [DW-1:0]     den_s2;

	dmn_pkg::dmn_ctl_t ctl_c [0:GW];
	logic [DW-1:0]     rem_c [0:GW];
	logic [GW-1:0]     low_c [0:GW];
	logic [DW-1:0]     den_c [0:GW];
	logic [GW-1:0]     quo_c [0:GW];

	logic          grey_valid_q;
	logic [GW-1:0] grey_q;
	logic          frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dmn_pkg::WIDTH_RESET;
			height_q <= dmn_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmn_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				dmn_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (width_q == '0) begin
			width_eff = SW'(1);
		end else if (32'(width_q) > 32'(MAX_SIDE)) begin
			width_eff = SW'(MAX_SIDE);
		end else begin
			width_eff = width_q;
		end
		priority if (height_q == '0) begin
			height_eff = SW'(1);
		end else if (32'(height_q) > 32'(MAX_SIDE)) begin
			height_eff = SW'(MAX_SIDE);
		end else begin
			height_eff = height_q;
		end
	end

	assign size = CW'(width_eff) * CW'(height_eff);

	assign adv         = !grey_valid_q || !grey_stall;
	assign depth_stall = !adv;

	dmn_tracker #(
		.DW(DW)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.sample_valid (depth_valid),
		.sample       (depth_sample),
		.size         (size),
		.ctl_s1       (ctl_s1),
		.x_s1         (x_s1),
		.den_s1       (den_s1)
	);

	// 255*x as 256*x - x
	assign num = {x_s1, {GW{1'b0}}} - {{GW{1'b0}}, x_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2 <= num[DW+GW-1:GW];
			low_s2 <= num[GW-1:0];
			den_s2 <= den_s1;
		end
	end

	assign ctl_c[0] = ctl_s2;
	assign rem_c[0] = rem_s2;
	assign low_c[0] = low_s2;
	assign den_c[0] = den_s2;
	assign quo_c[0] = '0;

	for (genvar i = 0; i < GW; i++) begin : g_cell
		dmn_div_cell #(
			.DW(DW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctl_in (ctl_c[i]),
			.rem_in (rem_c[i]),
			.low_in (low_c[i]),
			.den_in (den_c[i]),
			.quo_in (quo_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.low_q  (low_c[i+1]),
			.den_q  (den_c[i+1]),
			.quo_q  (quo_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_valid_q <= 1'b0;
		end else if (adv) begin
			grey_valid_q <= ctl_c[GW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_end_q <= ctl_c[GW].last;
			priority if (ctl_c[GW].zero) begin
				grey_q <= '0;
			end else if (ctl_c[GW].sat) begin
				grey_q <= dmn_pkg::GREY_MAX;
			end else begin
				grey_q <= quo_c[GW];
			end
		end
	end

	assign grey_valid = grey_valid_q;
	assign grey_level = grey_q;
	assign frame_end  = frame_end_q;

	// 255x prep leaves the top part below the divisor
	`DMN_ASSERT_IMPLIES(a_prep_bound, clk, arst_n, ctl_s2.valid && !ctl_s2.zero && !ctl_s2.sat, rem_s2 < den_s2)

endmodule

FILE: tb/dmn_grey_checker.sv
`timescale 1ns / 1ps
// Checker for the depth normalizer: predicts each grey transfer and compares it.
module dmn_grey_checker #(
	parameter int DEPTH_BITS = 24,
	parameter int MAX_SIDE   = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [dmn_pkg::SIDE_W-1:0]  cfg_data,
	input  logic                        depth_valid,
	input  logic                        depth_stall,
	input  logic [DEPTH_BITS-1:0]       depth_sample,
	input  logic                        grey_valid,
	input  logic                        grey_stall,
	input  logic [dmn_pkg::GREY_W-1:0]  grey_level,
	input  logic                        frame_end,
	output int                          grey_outstanding,
	output int                          mismatches
);
	import dmn_pkg::*;

	typedef struct packed {
		logic [GREY_W-1:0] grey;
		logic              frame_end;
	} grey_xfer_t;

	logic [SIDE_W-1:0]     width_reg;
	logic [SIDE_W-1:0]     height_reg;
	logic [DEPTH_BITS-1:0] depth_min;
	logic [DEPTH_BITS-1:0] depth_max;
	int unsigned           pass_pos;
	logic                  converting;
	grey_xfer_t            grey_expected[$];

	function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return 32'(v);
	endfunction

	function automatic logic [GREY_W-1:0] grey_of(input logic [DEPTH_BITS-1:0] d);
		longint unsigned num;
		longint unsigned den;
		if (depth_max <= depth_min || d <= depth_min)
			return '0;
		if (d >= depth_max)
			return GREY_MAX;
		num = 64'(d) - 64'(depth_min);
		num = num * 255;
		den = 64'(depth_max) - 64'(depth_min);
		return (num / den > 255) ? GREY_MAX : GREY_W'(num / den);
	endfunction

	function automatic void restart_frame();
		depth_min  = '1;
		depth_max  = '0;
		pass_pos   = 0;
		converting = 1'b0;
	endfunction

	task automatic normalize_depth(input logic [DEPTH_BITS-1:0] d);
		int unsigned frame_pixels;
		logic        is_last;
		grey_xfer_t  xfer;
		frame_pixels = clamp_side(width_reg) * clamp_side(height_reg);
		is_last = (pass_pos + 1 >= frame_pixels);
		if (!converting) begin
			if (d < depth_min)
				depth_min = d;
			if (d > depth_max)
				depth_max = d;
			pass_pos = is_last ? 0 : pass_pos + 1;
			converting = is_last;
		end else begin
			xfer.grey = grey_of(d);
			xfer.frame_end = is_last;
			grey_expected.push_back(xfer);
			if (is_last)
				restart_frame();
			else
				pass_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grey_xfer_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			restart_frame();
			grey_expected.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (depth_valid && !depth_stall)
				normalize_depth(depth_sample);
			if (grey_valid && !grey_stall) begin
				if (grey_expected.size() == 0) begin
					mismatches++;
					$display("%0t: grey transfer expected none, got grey %0d frame_end %0b",
						$time, grey_level, frame_end);
				end else begin
					want = grey_expected.pop_front();
					if (grey_level !== want.grey) begin
						mismatches++;
						$display("%0t: grey_level expected %0d, got %0d",
							$time, want.grey, grey_level);
					end
					if (frame_end !== want.frame_end) begin
						mismatches++;
						$display("%0t: frame_end expected %0b, got %0b",
							$time, want.frame_end, frame_end);
					end
				end
			end
		end
		grey_outstanding = grey_expected.size();
	end

endmodule

FILE: tb/depth_minmax_normalize_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the depth min-max normalizer: stimulus, watchdog and verdict.
module depth_minmax_normalize_unit_tb;
	import dmn_pkg::*;

	localparam int DEPTH_BITS   = 24;
	localparam int ITEM_TARGET  = 1050;
	localparam int DRAIN_CYCLES = 14;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 200;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	typedef enum {MIX_SPREAD, MIX_CLUSTER, MIX_FLAT, MIX_EXTREMES} depth_mix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_FRAME_WIDTH;
	logic [SIDE_W-1:0]     cfg_data = '0;
	logic                  depth_valid = 1'b0;
	logic [DEPTH_BITS-1:0] depth_sample = '0;
	logic                  grey_stall = 1'b0;
	wire                   depth_stall;
	wire                   grey_valid;
	wire  [GREY_W-1:0]     grey_level;
	wire                   frame_end;
	int                    grey_outstanding;
	int                    mismatches;
	int                    depth_sent = 0;
	int                    quiet_cycles = 0;
	bit                    tx_calm = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	depth_minmax_normalize_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.depth_valid  (depth_valid),
		.depth_stall  (depth_stall),
		.depth_sample (depth_sample),
		.grey_valid   (grey_valid),
		.grey_stall   (grey_stall),
		.grey_level   (grey_level),
		.frame_end    (frame_end)
	);

	dmn_grey_checker #(.DEPTH_BITS(DEPTH_BITS)) i_grey_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.depth_valid      (depth_valid),
		.depth_stall      (depth_stall),
		.depth_sample     (depth_sample),
		.grey_valid       (grey_valid),
		.grey_stall       (grey_stall),
		.grey_level       (grey_level),
		.frame_end        (frame_end),
		.grey_outstanding (grey_outstanding),
		.mismatches       (mismatches)
	);

	task automatic send_depth(input logic [DEPTH_BITS-1:0] d);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			depth_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		depth_valid <= 1'b1;
		depth_sample <= d;
		do @(posedge clk); while (depth_stall);
		depth_sent++;
	endtask

	// drop valid, drain outstanding results, then let the pipeline empty
	task automatic settle();
		depth_valid <= 1'b0;
		do @(posedge clk); while (grey_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SIDE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		settle();
		write_reg(REG_FRAME_WIDTH, SIDE_W'(w));
		write_reg(REG_FRAME_HEIGHT, SIDE_W'(h));
		cfg_we <= 1'b0;
	endtask

	initial begin : grey_sink
		int wait_n;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		forever begin
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			wait_n = calm ? 0 : $urandom_range(0, 9);
			// long hold-off so the pipeline fills and stalls its input
			if (taken == HOLD_AT)
				wait_n = HOLD_CYCLES;
			if (wait_n > 0) begin
				grey_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			grey_stall <= 1'b0;
			do @(posedge clk); while (!grey_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((depth_valid && !depth_stall) || (grey_valid && !grey_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("depth_minmax_normalize_unit verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned           w;
		int unsigned           h;
		int unsigned           npix;
		depth_mix_t            mix;
		logic [DEPTH_BITS-1:0] lo;
		logic [DEPTH_BITS-1:0] hi;
		logic [DEPTH_BITS-1:0] base;
		logic [DEPTH_BITS-1:0] d;
		npix = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size, then shrink mid-pass so the measuring pass ends early
		send_depth('0);
		send_depth(DEPTH_MAX);
		send_depth(24'h123456);
		set_frame(2, 2);
		send_depth(24'h800000);
		send_depth('0);
		send_depth(DEPTH_MAX);
		send_depth(24'h7FFFFF);
		send_depth(24'h000001);

		// flat frame
		set_frame(1, 3);
		repeat (3) send_depth(24'd5);
		send_depth(24'd5);
		send_depth('0);
		send_depth(DEPTH_MAX);

		// samples below the minimum and above the maximum
		set_frame(3, 1);
		send_depth(24'd100);
		send_depth(24'd200);
		send_depth(24'd150);
		send_depth(24'd50);
		send_depth(24'd250);
		send_depth(24'd199);

		// zero size reads as one pixel
		set_frame(0, 1);
		send_depth(24'hAAAAAA);
		send_depth(24'h555555);

		// oversized and largest sizes, then cut short
		set_frame(8191, 0);
		send_depth(24'd10);
		send_depth(24'd40);
		set_frame(4096, 4096);
		send_depth(24'd20);
		send_depth(24'd30);
		set_frame(1, 1);
		send_depth(24'd35);
		send_depth(24'd25);

		while (depth_sent < ITEM_TARGET) begin
			if (npix == 0 || $urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 7) == 0) begin
					w = $urandom_range(7, 40);
					h = $urandom_range(0, 1);
				end else begin
					w = $urandom_range(0, 6);
					h = $urandom_range(0, 6);
				end
				set_frame(w, h);
				npix = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
			end
			mix = depth_mix_t'($urandom_range(0, 3));
			base = DEPTH_BITS'($urandom_range(0, 32'(DEPTH_MAX) - 32));
			lo = '1;
			hi = '0;
			repeat (npix) begin
				case (mix)
					MIX_SPREAD:  d = DEPTH_BITS'($urandom);
					MIX_CLUSTER: d = DEPTH_BITS'(32'(base) + $urandom_range(0, 31));
					MIX_FLAT:    d = base;
					default: begin
						case ($urandom_range(0, 2))
							0:       d = '0;
							1:       d = DEPTH_MAX;
							default: d = DEPTH_BITS'($urandom);
						endcase
					end
				endcase
				if (d < lo)
					lo = d;
				if (d > hi)
					hi = d;
				send_depth(d);
			end
			repeat (npix) begin
				case ($urandom_range(0, 9))
					0:       d = lo;
					1:       d = hi;
					2:       d = DEPTH_BITS'($urandom);
					3:       d = lo - 1'b1;
					4:       d = hi + 1'b1;
					default: d = DEPTH_BITS'(32'(lo) + $urandom_range(0, 32'(hi - lo)));
				endcase
				send_depth(d);
			end
		end

		settle();
		if (mismatches == 0)
			$display("depth_minmax_normalize_unit verification clean");
		else
			$display("depth_minmax_normalize_unit verification failed");
		$finish;
	end

endmodule
